// File: hw/rtl/ialu_pkg.sv
// Shared types and constants for the integer ALU with divide.
// No dependencies; imported by every other file of the block.
package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH    = 32;
    localparam int MODE_WIDTH     = 5;
    localparam int ERR_WIDTH      = 2;
    localparam int IN_TDATA_WIDTH  = 72;
    localparam int OUT_TDATA_WIDTH = 40;

    typedef enum logic [MODE_WIDTH-1:0] {
        OP_NEG  = 5'd0,  OP_POS = 5'd1,  OP_NOT = 5'd2,  OP_MUL = 5'd3,
        OP_DIV  = 5'd4,  OP_MOD = 5'd5,  OP_ADD = 5'd6,  OP_SUB = 5'd7,
        OP_SHL  = 5'd8,  OP_SHR = 5'd9,  OP_AND = 5'd10, OP_OR  = 5'd11,
        OP_XOR  = 5'd12, OP_LT  = 5'd13, OP_LE  = 5'd14, OP_EQ  = 5'd15,
        OP_NE   = 5'd16, OP_GE  = 5'd17, OP_GT  = 5'd18, OP_BOOL = 5'd19,
        OP_HASH = 5'd20
    } op_t;

    localparam logic [ERR_WIDTH-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_WIDTH-1:0] ERR_DIVZERO = 2'd1;
    localparam logic [ERR_WIDTH-1:0] ERR_SHIFT   = 2'd2;

    typedef struct packed {
        logic                 valid;
        op_t                  mode;
        logic [ERR_WIDTH-1:0] err;
        logic                 negq;
        logic                 negr;
    } ctl_t;

endpackage

// File: hw/rtl/ialu_front.sv
// Front stages: operand capture, simple operations, partial products, divider set-up.
// Depends on ialu_pkg.
module ialu_front import ialu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  op_t                          in_mode,
    input  logic signed [FIELD_WIDTH-1:0] in_a,
    input  logic signed [FIELD_WIDTH-1:0] in_b,
    output ctl_t                         ctl,
    output logic [DATA_WIDTH-1:0]        res,
    output logic [DATA_WIDTH-1:0]        dividend,
    output logic [DATA_WIDTH-1:0]        divisor
);

    localparam int SW = $clog2(DATA_WIDTH);

    // stage 1
    logic                         v1_reg;
    op_t                          mode1_reg;
    logic signed [DATA_WIDTH-1:0] a1_reg, b1_reg;

    // stage 2
    ctl_t                  ctl2_reg, ctl2_next;
    logic [DATA_WIDTH-1:0] res2_reg, res2_next;
    logic [DATA_WIDTH-1:0] ua_reg, ua_next, ub_reg, ub_next;
    logic [63:0]           p0_reg, p0_next;
    logic [31:0]           p1_reg, p1_next, p2_reg, p2_next;

    // stage 3
    ctl_t                  ctl3_reg;
    logic [DATA_WIDTH-1:0] res3_reg, res3_next;
    logic [DATA_WIDTH-1:0] ua3_reg, ub3_reg;

    logic        an, bn, big;
    logic [SW-1:0] sh;
    logic [63:0] ax, bx, prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            ctl2_reg.valid <= 1'b0;
            ctl3_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg   <= in_valid;
            ctl2_reg <= ctl2_next;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= in_mode;
            a1_reg    <= DATA_WIDTH'(in_a);
            b1_reg    <= DATA_WIDTH'(in_b);
            res2_reg <= res2_next;
            ua_reg   <= ua_next;
            ub_reg   <= ub_next;
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            res3_reg <= res3_next;
            ua3_reg  <= ua_reg;
            ub3_reg  <= ub_reg;
        end
    end

    always_comb begin
        an  = a1_reg[DATA_WIDTH-1];
        bn  = b1_reg[DATA_WIDTH-1];
        big = $unsigned(b1_reg) >= DATA_WIDTH'(DATA_WIDTH);
        sh  = b1_reg[SW-1:0];
        ax  = 64'($unsigned(a1_reg));
        bx  = 64'($unsigned(b1_reg));
        p0_next = ax[31:0] * bx[31:0];
        p1_next = 32'(ax[31:0] * bx[63:32]);
        p2_next = 32'(ax[63:32] * bx[31:0]);
        ua_next = an ? DATA_WIDTH'(-a1_reg) : a1_reg;
        ub_next = bn ? DATA_WIDTH'(-b1_reg) : b1_reg;
        ctl2_next.valid = v1_reg;
        ctl2_next.mode  = mode1_reg;
        ctl2_next.negq  = an ^ bn;
        ctl2_next.negr  = an;
        ctl2_next.err   = ERR_OK;
        res2_next = '0;
        case (mode1_reg)
            OP_NEG:  res2_next = DATA_WIDTH'(-a1_reg);
            OP_POS:  res2_next = a1_reg;
            OP_NOT:  res2_next = ~a1_reg;
            OP_DIV, OP_MOD: begin
                if (b1_reg == '0) ctl2_next.err = ERR_DIVZERO;
            end
            OP_ADD:  res2_next = DATA_WIDTH'(a1_reg + b1_reg);
            OP_SUB:  res2_next = DATA_WIDTH'(a1_reg - b1_reg);
            OP_SHL: begin
                if (bn) ctl2_next.err = ERR_SHIFT;
                else if (!big) res2_next = a1_reg << sh;
            end
            OP_SHR: begin
                if (bn) ctl2_next.err = ERR_SHIFT;
                else if (big) res2_next = {DATA_WIDTH{an}};
                else res2_next = a1_reg >>> sh;
            end
            OP_AND:  res2_next = a1_reg & b1_reg;
            OP_OR:   res2_next = a1_reg | b1_reg;
            OP_XOR:  res2_next = a1_reg ^ b1_reg;
            OP_LT:   res2_next = DATA_WIDTH'(a1_reg < b1_reg);
            OP_LE:   res2_next = DATA_WIDTH'(a1_reg <= b1_reg);
            OP_EQ:   res2_next = DATA_WIDTH'(a1_reg == b1_reg);
            OP_NE:   res2_next = DATA_WIDTH'(a1_reg != b1_reg);
            OP_GE:   res2_next = DATA_WIDTH'(a1_reg >= b1_reg);
            OP_GT:   res2_next = DATA_WIDTH'(a1_reg > b1_reg);
            OP_BOOL: res2_next = DATA_WIDTH'(a1_reg != '0);
            OP_HASH: res2_next = (a1_reg == '1) ? {{(DATA_WIDTH-1){1'b1}}, 1'b0} : a1_reg;
            default: res2_next = '0;
        endcase
    end

    always_comb begin
        prod = p0_reg + {32'(p1_reg + p2_reg), 32'd0};
        res3_next = (ctl2_reg.mode == OP_MUL) ? DATA_WIDTH'(prod) : res2_reg;
    end

    assign ctl      = ctl3_reg;
    assign res      = res3_reg;
    assign dividend = ua3_reg;
    assign divisor  = ub3_reg;

endmodule

// File: hw/rtl/ialu_div_stage.sv
// One restoring-division step (one quotient bit) with the side payload carried along.
// Depends on ialu_pkg.
module ialu_div_stage import ialu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  ctl_t                  ctl_in,
    input  logic [DATA_WIDTH-1:0] res_in,
    input  logic [DATA_WIDTH-1:0] rem_in,
    input  logic [DATA_WIDTH-1:0] quo_in,
    input  logic [DATA_WIDTH-1:0] div_in,
    output ctl_t                  ctl_out,
    output logic [DATA_WIDTH-1:0] res_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] quo_out,
    output logic [DATA_WIDTH-1:0] div_out
);

    ctl_t                  ctl_reg;
    logic [DATA_WIDTH-1:0] res_reg, rem_reg, rem_next, quo_reg, quo_next, div_reg;
    logic [DATA_WIDTH:0]   trial;

    always_comb begin
        trial    = {rem_in, quo_in[DATA_WIDTH-1]} - {1'b0, div_in};
        rem_next = trial[DATA_WIDTH] ? {rem_in[DATA_WIDTH-2:0], quo_in[DATA_WIDTH-1]}
                                     : trial[DATA_WIDTH-1:0];
        quo_next = {quo_in[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            div_reg <= div_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign res_out = res_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign div_out = div_reg;

endmodule

// File: hw/rtl/integer_alu_with_divide_top.sv
// channel | dir | tdata fields (low bit up)               | handshake
// s_      | in  | mode[4:0] operand_a[36:5] operand_b[68:37] | s_tvalid/s_tready
// m_      | out | result_value[31:0] error_code[33:32]     | m_tvalid/m_tready
// One item per cycle while the output is not stalled; the divider resolves one
// quotient bit per stage. Synchronous active-low reset clears valid bits only.
// The whole pipeline advances when the output register is empty or being taken.
// Top level; depends on ialu_pkg, ialu_front, ialu_div_stage.
module integer_alu_with_divide_top import ialu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,   // mode, operand_a, operand_b
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_TDATA_WIDTH-1:0] m_tdata    // result_value, error_code
);

    logic en;
    ctl_t                  ctl_s [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] res_s [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] rem_s [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] quo_s [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] div_s [DATA_WIDTH+1];

    logic                       m_tvalid_reg;
    logic [OUT_TDATA_WIDTH-1:0] m_tdata_reg, m_tdata_next;
    ctl_t                       fin;
    logic [DATA_WIDTH-1:0]      r;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign rem_s[0] = '0;

    ialu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_mode  (op_t'(s_tdata[4:0])),
        .in_a     (s_tdata[36:5]),
        .in_b     (s_tdata[68:37]),
        .ctl      (ctl_s[0]),
        .res      (res_s[0]),
        .dividend (quo_s[0]),
        .divisor  (div_s[0])
    );

    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_div
        ialu_div_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl_s[i]),
            .res_in  (res_s[i]),
            .rem_in  (rem_s[i]),
            .quo_in  (quo_s[i]),
            .div_in  (div_s[i]),
            .ctl_out (ctl_s[i+1]),
            .res_out (res_s[i+1]),
            .rem_out (rem_s[i+1]),
            .quo_out (quo_s[i+1]),
            .div_out (div_s[i+1])
        );
    end

    always_comb begin
        fin = ctl_s[DATA_WIDTH];
        case (fin.mode)
            OP_DIV:  r = fin.negq ? DATA_WIDTH'(-quo_s[DATA_WIDTH]) : quo_s[DATA_WIDTH];
            OP_MOD:  r = fin.negr ? DATA_WIDTH'(-rem_s[DATA_WIDTH]) : rem_s[DATA_WIDTH];
            default: r = res_s[DATA_WIDTH];
        endcase
        if (fin.err != ERR_OK) r = '0;
        m_tdata_next = {6'd0, fin.err, FIELD_WIDTH'($signed(r))};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= fin.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: tb/sv/integer_alu_with_divide_top_tb.sv
// Testbench for integer_alu_with_divide_top: random and directed ALU operations
// checked against a behavioural predictor held in a small scoreboard class.
// Depends on ialu_pkg and the block's RTL.
`timescale 1ns / 1ps

module integer_alu_with_divide_top_tb import ialu_pkg::*;;

    localparam int W = DATA_WIDTH_DEF;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  err;
    } alu_out_t;

    class alu_scoreboard;
        alu_out_t pending[$];
        int       errors;

        function alu_out_t compute(logic [4:0] mode, logic [31:0] a, logic [31:0] b);
            alu_out_t   o;
            logic [63:0] prod;
            logic [31:0] ua, ub, q, rm;
            o.value = '0;
            o.err = ERR_OK;
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            case (mode)
                OP_NEG:  o.value = -a;
                OP_POS:  o.value = a;
                OP_NOT:  o.value = ~a;
                OP_MUL: begin
                    prod = a * b;
                    o.value = prod[31:0];
                end
                OP_DIV, OP_MOD: begin
                    if (b == 0) begin
                        o.err = ERR_DIVZERO;
                    end else begin
                        q = ua / ub;
                        rm = ua % ub;
                        if (mode == OP_DIV) o.value = (a[31] != b[31]) ? -q : q;
                        else o.value = a[31] ? -rm : rm;
                    end
                end
                OP_ADD:  o.value = a + b;
                OP_SUB:  o.value = a - b;
                OP_SHL: begin
                    if (b[31]) o.err = ERR_SHIFT;
                    else if (b >= W) o.value = '0;
                    else o.value = a << b;
                end
                OP_SHR: begin
                    if (b[31]) o.err = ERR_SHIFT;
                    else if (b >= W) o.value = {32{a[31]}};
                    else o.value = $signed(a) >>> b;
                end
                OP_AND:  o.value = a & b;
                OP_OR:   o.value = a | b;
                OP_XOR:  o.value = a ^ b;
                OP_LT:   o.value = 32'($signed(a) <  $signed(b));
                OP_LE:   o.value = 32'($signed(a) <= $signed(b));
                OP_EQ:   o.value = 32'(a == b);
                OP_NE:   o.value = 32'(a != b);
                OP_GE:   o.value = 32'($signed(a) >= $signed(b));
                OP_GT:   o.value = 32'($signed(a) >  $signed(b));
                OP_BOOL: o.value = 32'(a != 0);
                OP_HASH: o.value = (a == 32'hFFFF_FFFF) ? 32'hFFFF_FFFE : a;
                default: o.value = '0;
            endcase
            return o;
        endfunction

        function void note_operation(logic [IN_TDATA_WIDTH-1:0] d);
            pending.push_back(compute(d[4:0], d[36:5], d[68:37]));
        endfunction

        function void check_result(logic [OUT_TDATA_WIDTH-1:0] d);
            alu_out_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.value) begin
                $error("result_value: expected %h actual %h", e.value, d[31:0]);
                errors++;
            end
            if (d[33:32] !== e.err) begin
                $error("error_code: expected %0d actual %0d", e.err, d[33:32]);
                errors++;
            end
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_TDATA_WIDTH-1:0]  s_tdata;   // mode, operand_a, operand_b
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_TDATA_WIDTH-1:0] m_tdata;   // result_value, error_code

    alu_scoreboard sb;
    int            send_idle;
    int            recv_stall;
    int            cycles;
    bit            sending_done;

    integer_alu_with_divide_top dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 400000) begin
                $display("integer_alu_with_divide_top_tb failed");
                $finish;
            end
        end
    end

    // result side: random stall, check each transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    function logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(40));
            4: return -32'($urandom_range(40));
            5: return 32'($urandom_range(300)) - 32'd150;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(logic [4:0] mode, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, b, a, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_operation({3'b0, b, a, mode});
    endtask

    task automatic run_phase(int n, int si, int rs);
        send_idle  = si;
        recv_stall = rs;
        repeat (n) send_op(5'($urandom_range(31)), pick_operand(), pick_operand());
    endtask

    initial begin
        sb = new();
        sb.errors = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        send_idle = 0;
        recv_stall = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: each opcode, divide and shift corner cases
        for (int op = 0; op <= OP_HASH; op++) send_op(5'(op), 32'hFFFF_FFFF, 32'd7);
        send_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_DIV, 32'd5, 32'd0);
        send_op(OP_MOD, -32'd7, 32'd2);
        send_op(OP_SHL, 32'd1, -32'd1);
        send_op(OP_SHR, 32'h8000_0000, 32'd40);
        send_op(5'd31, 32'h7FFF_FFFF, 32'h8000_0000);

        run_phase(500, 0, 0);
        run_phase(480, 55, 0);
        run_phase(480, 0, 55);
        run_phase(480, 16, 16);
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (W + 10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("integer_alu_with_divide_top_tb passed");
        end else begin
            $display("integer_alu_with_divide_top_tb failed");
        end
        $finish;
    end
endmodule

// File: files.f
hw/rtl/ialu_pkg.sv
hw/rtl/ialu_front.sv
hw/rtl/ialu_div_stage.sv
hw/rtl/integer_alu_with_divide_top.sv
tb/sv/integer_alu_with_divide_top_tb.sv
